@@ design/tcqs_pkg.sv @@
package tcqs_pkg;

  localparam int unsigned FifoDepth  = 256;
  localparam int unsigned TagWidth   = 16;
  localparam int unsigned RoundMax   = 64;
  localparam int unsigned NumClasses = 3;

  localparam int unsigned PtrW   = $clog2(FifoDepth);
  localparam int unsigned CntW   = $clog2(FifoDepth + 1);
  localparam int unsigned RamD   = NumClasses * FifoDepth;
  localparam int unsigned AddrW  = $clog2(RamD);
  localparam int unsigned QuotaW = 7;
  localparam int unsigned RemW   = $clog2(RoundMax + 1);
  localparam int unsigned ClsW   = 2;

  localparam logic [QuotaW-1:0] QuotaHighReset = 7'd32;
  localparam logic [QuotaW-1:0] QuotaMidReset  = 7'd19;
  localparam logic [QuotaW-1:0] QuotaLowReset  = 7'd13;

  localparam logic [1:0] KindAck   = 2'd0;
  localparam logic [1:0] KindGrant = 2'd1;
  localparam logic [1:0] KindEmpty = 2'd2;

  localparam logic [ClsW-1:0] ClsHigh = 2'd0;
  localparam logic [ClsW-1:0] ClsMid  = 2'd1;
  localparam logic [ClsW-1:0] ClsLow  = 2'd2;

  localparam logic [1:0] RegQuotaHigh = 2'd0;
  localparam logic [1:0] RegQuotaMid  = 2'd1;
  localparam logic [1:0] RegQuotaLow  = 2'd2;

  typedef logic [CntW-1:0] cnt_t;
  typedef logic [PtrW-1:0] ptr_t;

  typedef struct packed {
    logic                push;
    logic                pop;
    logic [ClsW-1:0]     cls;
    logic [TagWidth-1:0] tag;
  } queue_cmd_t;

  function automatic logic [AddrW-1:0] fifo_addr(logic [ClsW-1:0] cls, ptr_t ptr);
    logic [AddrW-1:0] base;
    base = AddrW'(cls) * AddrW'(FifoDepth);
    return base + AddrW'(ptr);
  endfunction

  function automatic ptr_t ptr_next(ptr_t ptr);
    return (ptr == ptr_t'(FifoDepth - 1)) ? '0 : ptr + ptr_t'(1);
  endfunction

endpackage

@@ design/tcqs_ram.sv @@
module tcqs_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 768
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ design/tcqs_queues.sv @@
module tcqs_queues
  import tcqs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  queue_cmd_t          cmd_i,
  output cnt_t [2:0]          fill_o,
  output logic [TagWidth-1:0] rd_tag_o
);

  ptr_t [2:0] head_q, head_d;
  ptr_t [2:0] tail_q, tail_d;
  cnt_t [2:0] fill_q, fill_d;

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    fill_d = fill_q;
    if (cmd_i.push) begin
      tail_d[cmd_i.cls] = ptr_next(tail_q[cmd_i.cls]);
      fill_d[cmd_i.cls] = fill_q[cmd_i.cls] + cnt_t'(1);
    end else if (cmd_i.pop) begin
      head_d[cmd_i.cls] = ptr_next(head_q[cmd_i.cls]);
      fill_d[cmd_i.cls] = fill_q[cmd_i.cls] - cnt_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      fill_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      fill_q <= fill_d;
    end
  end

  tcqs_ram #(
    .Width(TagWidth),
    .Depth(RamD)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.push),
    .waddr_i(fifo_addr(cmd_i.cls, tail_q[cmd_i.cls])),
    .wdata_i(cmd_i.tag),
    .re_i   (cmd_i.pop),
    .raddr_i(fifo_addr(cmd_i.cls, head_q[cmd_i.cls])),
    .rdata_o(rd_tag_o)
  );

  assign fill_o = fill_q;

endmodule

@@ design/three_class_quota_scheduler.sv @@
// Three-class quota scheduler: tags are queued per class (high, mid, low) and
// a round item drains them, first by per-class quota and then round robin,
// one grant per result, or one empty result if a round has no grants. An
// enqueue returns one acknowledgement. A round passes through an issue and a
// data state per grant, set by the registered read of the shared tag memory
// and the single pop unit; the input is not ready until the round's last grant
// has been loaded into the output register, and a stalled output holds the
// sequencer. The tag memory needs no clearing pass after reset.
module three_class_quota_scheduler
  import tcqs_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // priority_req[1:0], msg_tag[17:2], zero pad
  input  logic [0:0]  s_axis_tuser,   // req_type[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // served_class[1:0], granted_tag[17:2], accepted[18],
                                      // zero pad
  output logic [1:0]  m_axis_tuser,   // kind[1:0]
  output logic        m_axis_tlast,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [1:0] StIdle  = 2'd0;
  localparam logic [1:0] StIssue = 2'd1;
  localparam logic [1:0] StData  = 2'd2;

  logic [1:0] state_q, state_d;
  logic [QuotaW-1:0] quota_q [NumClasses];
  logic [QuotaW-1:0] take_q [NumClasses];
  logic [QuotaW-1:0] take_d [NumClasses];
  logic [RemW-1:0]   rem_q, rem_d;
  logic [ClsW-1:0]   rr_q, rr_d;
  logic [ClsW-1:0]   pend_cls_q, pend_cls_d;
  logic              pend_last_q, pend_last_d;

  logic                m_valid_q, m_valid_d;
  logic [1:0]          out_kind_q, out_kind_d;
  logic [ClsW-1:0]     out_cls_q, out_cls_d;
  logic [TagWidth-1:0] out_tag_q, out_tag_d;
  logic                out_acc_q, out_acc_d;
  logic                out_last_q, out_last_d;

  queue_cmd_t          qcmd;
  cnt_t [2:0]          fill;
  logic [TagWidth-1:0] rd_tag;

  logic            out_free, in_acc, is_round, full, quota_phase, found, issue_fire;
  logic [1:0]      pri;
  logic [ClsW-1:0] enq_cls, sel_cls, cand;
  logic [8:0]      budget_sum;
  logic [RemW-1:0] budget, grants;
  logic [CntW+1:0] fill_sum;
  logic            cfg_wr;
  logic [1:0]      cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_comb begin
    case (cfg_idx)
      RegQuotaHigh: prdata = 32'(quota_q[0]);
      RegQuotaMid:  prdata = 32'(quota_q[1]);
      RegQuotaLow:  prdata = 32'(quota_q[2]);
      default:      prdata = '0;
    endcase
  end

  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == StIdle) && out_free;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign is_round      = s_axis_tuser[0];
  assign pri           = s_axis_tdata[1:0];
  assign enq_cls       = (pri > 2'd2) ? ClsLow : pri;
  assign full          = fill[enq_cls] >= cnt_t'(FifoDepth);
  assign issue_fire    = (state_q == StIssue) && out_free;

  assign budget_sum = 9'(quota_q[0]) + 9'(quota_q[1]) + 9'(quota_q[2]);
  assign budget     = (budget_sum > 9'(RoundMax)) ? RemW'(RoundMax) : RemW'(budget_sum);
  assign fill_sum   = (CntW+2)'(fill[0]) + (CntW+2)'(fill[1]) + (CntW+2)'(fill[2]);
  assign grants     = (fill_sum < (CntW+2)'(budget)) ? RemW'(fill_sum) : budget;

  // pick the class to serve: quota order first, then round robin over nonempty queues
  always_comb begin
    quota_phase = 1'b0;
    found       = 1'b0;
    sel_cls     = ClsHigh;
    cand        = rr_q;
    for (int c = NumClasses - 1; c >= 0; c--) begin
      if (take_q[c] != '0) begin
        quota_phase = 1'b1;
        sel_cls     = ClsW'(c);
      end
    end
    if (!quota_phase) begin
      for (int k = 0; k < NumClasses; k++) begin
        if (!found && fill[cand] != '0) begin
          found   = 1'b1;
          sel_cls = cand;
        end
        cand = (cand == ClsLow) ? ClsHigh : cand + ClsW'(1);
      end
    end
  end

  assign qcmd.push = in_acc && !is_round && !full;
  assign qcmd.pop  = issue_fire;
  assign qcmd.cls  = issue_fire ? sel_cls : enq_cls;
  assign qcmd.tag  = s_axis_tdata[17:2];

  tcqs_queues u_queues (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (qcmd),
    .fill_o  (fill),
    .rd_tag_o(rd_tag)
  );

  always_comb begin
    state_d     = state_q;
    take_d      = take_q;
    rem_d       = rem_q;
    rr_d        = rr_q;
    pend_cls_d  = pend_cls_q;
    pend_last_d = pend_last_q;
    m_valid_d   = m_valid_q && !m_axis_tready;
    out_kind_d  = out_kind_q;
    out_cls_d   = out_cls_q;
    out_tag_d   = out_tag_q;
    out_acc_d   = out_acc_q;
    out_last_d  = out_last_q;
    case (state_q)
      StIdle: begin
        if (in_acc) begin
          if (!is_round) begin
            m_valid_d  = 1'b1;
            out_kind_d = KindAck;
            out_cls_d  = ClsHigh;
            out_tag_d  = '0;
            out_acc_d  = !full;
            out_last_d = 1'b1;
          end else begin
            for (int c = 0; c < NumClasses; c++) begin
              take_d[c] = (fill[c] < cnt_t'(quota_q[c])) ? QuotaW'(fill[c]) : quota_q[c];
            end
            rem_d = grants;
            rr_d  = ClsHigh;
            if (grants == '0) begin
              m_valid_d  = 1'b1;
              out_kind_d = KindEmpty;
              out_cls_d  = ClsHigh;
              out_tag_d  = '0;
              out_acc_d  = 1'b0;
              out_last_d = 1'b1;
            end else begin
              state_d = StIssue;
            end
          end
        end
      end
      StIssue: begin
        if (issue_fire) begin
          if (quota_phase) begin
            take_d[sel_cls] = take_q[sel_cls] - QuotaW'(1);
          end else begin
            rr_d = (sel_cls == ClsLow) ? ClsHigh : sel_cls + ClsW'(1);
          end
          rem_d       = rem_q - RemW'(1);
          pend_cls_d  = sel_cls;
          pend_last_d = (rem_q == RemW'(1));
          state_d     = StData;
        end
      end
      StData: begin
        m_valid_d  = 1'b1;
        out_kind_d = KindGrant;
        out_cls_d  = pend_cls_q;
        out_tag_d  = rd_tag;
        out_acc_d  = 1'b0;
        out_last_d = pend_last_q;
        state_d    = pend_last_q ? StIdle : StIssue;
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      quota_q[0] <= QuotaHighReset;
      quota_q[1] <= QuotaMidReset;
      quota_q[2] <= QuotaLowReset;
      for (int c = 0; c < NumClasses; c++) begin
        take_q[c] <= '0;
      end
      rem_q      <= '0;
      rr_q       <= ClsHigh;
      m_valid_q  <= 1'b0;
    end else begin
      state_q   <= state_d;
      take_q    <= take_d;
      rem_q     <= rem_d;
      rr_q      <= rr_d;
      m_valid_q <= m_valid_d;
      if (cfg_wr) begin
        case (cfg_idx)
          RegQuotaHigh: quota_q[0] <= pwdata[QuotaW-1:0];
          RegQuotaMid:  quota_q[1] <= pwdata[QuotaW-1:0];
          RegQuotaLow:  quota_q[2] <= pwdata[QuotaW-1:0];
          default:      ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    pend_cls_q  <= pend_cls_d;
    pend_last_q <= pend_last_d;
    out_kind_q  <= out_kind_d;
    out_cls_q   <= out_cls_d;
    out_tag_q   <= out_tag_d;
    out_acc_q   <= out_acc_d;
    out_last_q  <= out_last_d;
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tdata  = {5'b00000, out_acc_q, out_tag_q, out_cls_q};

`ifndef SYNTHESIS
  a_issue_has_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StIssue |-> rem_q != '0)
    else $error("grant issued with no grants left in round");

  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    issue_fire |-> fill[sel_cls] != '0)
    else $error("pop from an empty class queue");

  a_ready_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> state_q == StIdle)
    else $error("input ready while a round is in progress");

  a_data_loads_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == StData |=> m_axis_tvalid && out_kind_q == KindGrant)
    else $error("grant not presented after memory read");
`endif

endmodule

@@ tb/sv/three_class_quota_scheduler_tb.sv @@
module three_class_quota_scheduler_tb
  import tcqs_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] RegUnused = 2'd3;
  localparam int unsigned ResetCycles = 9;

  typedef struct packed {
    logic [1:0]          kind;
    logic [ClsW-1:0]     cls;
    logic [TagWidth-1:0] tag;
    logic                acc;
    logic                last;
  } sched_result_t;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata;   // priority_req[1:0], msg_tag[17:2], zero pad
  logic [0:0]  s_axis_tuser;   // req_type[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [23:0] m_axis_tdata;   // served_class[1:0], granted_tag[17:2], accepted[18]
  logic [1:0]  m_axis_tuser;   // kind[1:0]
  logic        m_axis_tlast;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // scheduler state as predicted by the testbench
  logic [TagWidth-1:0] tag_store [NumClasses][FifoDepth];
  int unsigned         head_ptr  [NumClasses];
  int unsigned         tail_ptr  [NumClasses];
  int unsigned         fill_cnt  [NumClasses];
  logic [QuotaW-1:0]   quota_q   [NumClasses];

  sched_result_t pending_results [$];
  sched_result_t held_grant;
  bit            have_held;

  int idle_pct;
  int stall_pct;
  int err_count;

  three_class_quota_scheduler u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    #7_200_000;
    $display("FAILURE");
    $finish;
  end

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(99) >= stall_pct);
  end

  // scoreboard: compare every accepted item with the oldest prediction
  always @(posedge clk_i) begin : check_output
    sched_result_t got;
    sched_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.kind = m_axis_tuser;
      got.cls  = m_axis_tdata[1:0];
      got.tag  = m_axis_tdata[17:2];
      got.acc  = m_axis_tdata[18];
      got.last = m_axis_tlast;
      if (pending_results.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected item: kind %0d class %0d tag %h acc %0d last %0d",
                   got.kind, got.cls, got.tag, got.acc, got.last);
      end else begin
        want = pending_results.pop_front();
        if (got.kind !== want.kind || got.cls !== want.cls || got.tag !== want.tag ||
            got.acc !== want.acc || got.last !== want.last) begin
          err_count++;
          if (err_count <= 10)
            $display({"mismatch: exp kind %0d class %0d tag %h acc %0d last %0d, ",
                      "got kind %0d class %0d tag %h acc %0d last %0d"},
                     want.kind, want.cls, want.tag, want.acc, want.last,
                     got.kind, got.cls, got.tag, got.acc, got.last);
        end
      end
    end
  end

  function automatic sched_result_t make_result(logic [1:0] kind, logic [ClsW-1:0] cls,
                                                logic [TagWidth-1:0] tag, logic acc,
                                                logic last);
    sched_result_t r;
    r.kind = kind;
    r.cls  = cls;
    r.tag  = tag;
    r.acc  = acc;
    r.last = last;
    return r;
  endfunction

  // pop one tag of class c and hold it back until we know whether it ends the round
  function automatic void grant_from(int unsigned c);
    logic [TagWidth-1:0] t;
    t = tag_store[c][head_ptr[c]];
    head_ptr[c] = (head_ptr[c] + 1 >= FifoDepth) ? 0 : head_ptr[c] + 1;
    fill_cnt[c]--;
    if (have_held) pending_results.push_back(held_grant);
    held_grant = make_result(KindGrant, ClsW'(c), t, 1'b0, 1'b0);
    have_held = 1'b1;
  endfunction

  function automatic void model_request(logic req, logic [1:0] pri, logic [TagWidth-1:0] tag);
    int unsigned c, budget, queued, left, total, take, n, i, j;
    int unsigned snap [NumClasses];
    bit found;
    if (!req) begin
      c = (pri > 2) ? 2 : pri;
      if (fill_cnt[c] >= FifoDepth) begin
        pending_results.push_back(make_result(KindAck, ClsHigh, '0, 1'b0, 1'b1));
      end else begin
        tag_store[c][tail_ptr[c]] = tag;
        tail_ptr[c] = (tail_ptr[c] + 1 >= FifoDepth) ? 0 : tail_ptr[c] + 1;
        fill_cnt[c]++;
        pending_results.push_back(make_result(KindAck, ClsHigh, '0, 1'b1, 1'b1));
      end
      return;
    end
    budget = quota_q[0] + quota_q[1] + quota_q[2];
    if (budget > RoundMax) budget = RoundMax;
    for (c = 0; c < NumClasses; c++) snap[c] = fill_cnt[c];
    have_held = 1'b0;
    n = 0;
    for (c = 0; c < NumClasses; c++) begin
      take = (snap[c] < quota_q[c]) ? snap[c] : quota_q[c];
      for (j = 0; j < take && n < budget; j++) begin
        grant_from(c);
        n++;
      end
    end
    queued = snap[0] + snap[1] + snap[2] - n;
    left   = budget - n;
    total  = (queued < left) ? queued : left;
    i = 0;
    while (total > 0) begin
      found = 1'b0;
      for (j = 0; j < NumClasses; j++) begin
        c = i % NumClasses;
        i++;
        if (fill_cnt[c] > 0) begin
          grant_from(c);
          n++;
          found = 1'b1;
          break;
        end
      end
      if (!found) break;
      total--;
    end
    if (n == 0) begin
      pending_results.push_back(make_result(KindEmpty, ClsHigh, '0, 1'b0, 1'b1));
    end else begin
      held_grant.last = 1'b1;
      pending_results.push_back(held_grant);
    end
  endfunction

  task automatic send_request(input logic req, input logic [1:0] pri,
                              input logic [TagWidth-1:0] tag);
    @(negedge clk_i);
    if ($urandom_range(99) < idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
      while ($urandom_range(99) < idle_pct) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {6'b0, tag, pri};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    model_request(req, pri, tag);
  endtask

  task automatic enqueue(input logic [1:0] pri, input logic [TagWidth-1:0] tag);
    send_request(1'b0, pri, tag);
  endtask

  task automatic run_round();
    send_request(1'b1, 2'($urandom_range(3)), TagWidth'($urandom));
  endtask

  // sender stops until every predicted item has come out
  task automatic wait_drained();
    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [QuotaW-1:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= 32'(val);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    if (idx != RegUnused) quota_q[idx] = val;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic write_quotas(input logic [QuotaW-1:0] qh, input logic [QuotaW-1:0] qm,
                              input logic [QuotaW-1:0] ql);
    wait_drained();
    write_reg(RegQuotaHigh, qh);
    write_reg(RegQuotaMid, qm);
    write_reg(RegQuotaLow, ql);
  endtask

  task automatic set_idling(input int sender, input int receiver);
    idle_pct  = sender;
    stall_pct = receiver;
  endtask

  function automatic logic [QuotaW-1:0] pick_quota();
    case ($urandom_range(3))
      0: return '0;
      1: return QuotaW'(RoundMax);
      default: return QuotaW'($urandom_range(RoundMax));
    endcase
  endfunction

  task automatic test_directed();
    set_idling(0, 0);
    run_round();
    enqueue(2'd0, 16'h0000);
    enqueue(2'd1, 16'hffff);
    enqueue(2'd2, 16'h5555);
    enqueue(2'd3, 16'haaaa);
    run_round();
    // zero budget, and a write to an unused register
    write_quotas('0, '0, '0);
    write_reg(RegUnused, 7'h7f);
    enqueue(2'd0, 16'h1234);
    run_round();
    write_quotas(7'd1, '0, '0);
    run_round();
    // quota phase on low only, then round robin over high and mid
    write_quotas('0, '0, 7'd4);
    enqueue(2'd0, 16'h0001);
    enqueue(2'd0, 16'h0002);
    enqueue(2'd1, 16'h0010);
    enqueue(2'd1, 16'h0020);
    enqueue(2'd3, 16'h0100);
    enqueue(2'd2, 16'h0200);
    run_round();
    run_round();
    run_round();
  endtask

  task automatic test_full_and_saturation();
    int k;
    set_idling(19, 19);
    write_quotas(QuotaW'(RoundMax), QuotaW'(RoundMax), QuotaW'(RoundMax));
    for (k = 0; k < 5; k++) enqueue(2'd0, TagWidth'($urandom));
    for (k = 0; k < 3; k++) enqueue(2'd1, TagWidth'($urandom));
    for (k = 0; k < FifoDepth; k++) enqueue(2'(2 + $urandom_range(1)), TagWidth'($urandom));
    enqueue(2'd2, TagWidth'($urandom));
    enqueue(2'd3, TagWidth'($urandom));
    enqueue(2'd0, TagWidth'($urandom));
    for (k = 0; k < 6; k++) run_round();
  endtask

  task automatic test_random();
    int ph, k;
    int sender_mode [4];
    int recv_mode [4];
    sender_mode = '{0, 79, 0, 19};
    recv_mode   = '{0, 0, 79, 19};
    for (ph = 0; ph < 4; ph++) begin
      write_quotas(pick_quota(), pick_quota(), pick_quota());
      set_idling(sender_mode[ph], recv_mode[ph]);
      for (k = 0; k < 42; k++) begin
        if (ph == 1 && k == 21) wait_drained();
        if ($urandom_range(99) < 70)
          enqueue(2'($urandom_range(3)), TagWidth'($urandom));
        else
          run_round();
      end
    end
  endtask

  initial begin
    int c;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    idle_pct      = 0;
    stall_pct     = 0;
    err_count     = 0;
    have_held     = 1'b0;
    for (c = 0; c < NumClasses; c++) begin
      head_ptr[c] = 0;
      tail_ptr[c] = 0;
      fill_cnt[c] = 0;
    end
    quota_q[0] = QuotaHighReset;
    quota_q[1] = QuotaMidReset;
    quota_q[2] = QuotaLowReset;
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    test_full_and_saturation();
    test_random();

    wait_drained();
    repeat (20) @(posedge clk_i);
    if (err_count == 0 && pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/tcqs_pkg.sv
design/tcqs_ram.sv
design/tcqs_queues.sv
design/three_class_quota_scheduler.sv
tb/sv/three_class_quota_scheduler_tb.sv
